### hw/rtl/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// shared constants, opcodes, status codes and types of the stack execute unit
// ----------------------------------------------------------------------------
`default_nettype none
package smeu_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int WORD_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int SP_W        = ADDR_W + 1;
  localparam int CMP_W       = (SP_W > 8) ? SP_W : 8;
  localparam int DIV_CNT_W   = $clog2(WORD_W + 1);
  localparam int OUT_W       = 32;
  localparam int DEPTH_W     = 9;

  localparam logic [3:0] OP_PUSH8 = 4'd0;
  localparam logic [3:0] OP_PICK  = 4'd1;
  localparam logic [3:0] OP_ROLL  = 4'd2;
  localparam logic [3:0] OP_ADD   = 4'd3;
  localparam logic [3:0] OP_SUB   = 4'd4;
  localparam logic [3:0] OP_MUL   = 4'd5;
  localparam logic [3:0] OP_DIV   = 4'd6;
  localparam logic [3:0] OP_MOD   = 4'd7;
  localparam logic [3:0] OP_CALL  = 4'd8;

  localparam logic [2:0] K_PUSH = 3'd0;
  localparam logic [2:0] K_PICK = 3'd1;
  localparam logic [2:0] K_ROLL = 3'd2;
  localparam logic [2:0] K_ALU  = 3'd3;
  localparam logic [2:0] K_CALL = 3'd4;
  localparam logic [2:0] K_BAD  = 3'd5;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_UNDER  = 3'd1;
  localparam logic [2:0] ST_OVER   = 3'd2;
  localparam logic [2:0] ST_DIVZ   = 3'd3;
  localparam logic [2:0] ST_BADIDX = 3'd4;
  localparam logic [2:0] ST_BADOP  = 3'd5;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] op;
    logic [7:0] imm;
  } cmd_t;

  // sign-extend or cut a stack word to the 32-bit result fields
  function automatic logic [OUT_W-1:0] to_out(input logic [WORD_W-1:0] w);
    logic [63:0] t;
    t = 64'(signed'(w));
    return t[OUT_W-1:0];
  endfunction

endpackage
`default_nettype wire

### hw/rtl/smeu_ram.sv
// ----------------------------------------------------------------------------
// smeu_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module smeu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### hw/rtl/smeu_front.sv
// ----------------------------------------------------------------------------
// smeu_front
// accepts instructions, classifies the opcode, two-entry queue to the back end
// ----------------------------------------------------------------------------
`default_nettype none
module smeu_front import smeu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [3:0] op,
  input  wire logic [7:0] imm,
  output logic            q_valid,
  output cmd_t            q_cmd,
  input  wire logic       q_pop
);

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cmd_t       dec;

  always_comb begin
    dec.op  = op;
    dec.imm = imm;
    case (op)
      OP_PUSH8: dec.kind = K_PUSH;
      OP_PICK:  dec.kind = K_PICK;
      OP_ROLL:  dec.kind = K_ROLL;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: dec.kind = K_ALU;
      OP_CALL:  dec.kind = K_CALL;
      default:  dec.kind = K_BAD;
    endcase
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != 2'd0);
  assign q_cmd    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

### hw/rtl/smeu_div.sv
// ----------------------------------------------------------------------------
// smeu_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module smeu_div import smeu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [WORD_W-1:0] dividend,
  input  wire logic [WORD_W-1:0] divisor,
  output logic                   done,
  output logic      [WORD_W-1:0] quot,
  output logic      [WORD_W-1:0] rem
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    dvs;
  logic [WORD_W:0]      rem_sh;
  logic [WORD_W:0]      diff;

  assign rem_sh = {rem, quot[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(WORD_W);
        rem  <= '0;
        quot <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!diff[WORD_W]) begin
          rem  <= diff[WORD_W-1:0];
          quot <= {quot[WORD_W-2:0], 1'b1};
        end else begin
          rem  <= rem_sh[WORD_W-1:0];
          quot <= {quot[WORD_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### hw/rtl/smeu_back.sv
// ----------------------------------------------------------------------------
// smeu_back
// executes queued instructions on the stack memory and registers the result
// ----------------------------------------------------------------------------
`default_nettype none
module smeu_back import smeu_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire cmd_t              q_cmd,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [OUT_W-1:0]  top_value,
  output logic      [DEPTH_W-1:0] depth,
  output logic                   call_valid,
  output logic      [OUT_W-1:0]  call_target,
  output logic      [2:0]        status
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_PICK    = 4'd1;
  localparam logic [3:0] S_ROLL_V  = 4'd2;
  localparam logic [3:0] S_ROLL_W  = 4'd3;
  localparam logic [3:0] S_ROLL_L  = 4'd4;
  localparam logic [3:0] S_ALU_A   = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_ALU_WR  = 4'd7;
  localparam logic [3:0] S_CALL_RD = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic [2:0]        st_next;
  cmd_t              cmd;
  logic [SP_W-1:0]   sp;
  logic [WORD_W-1:0] top;
  logic [ADDR_W-1:0] idx;
  logic [WORD_W-1:0] hold;
  logic [WORD_W-1:0] res;
  logic [2:0]        st;
  logic              cval;
  logic [WORD_W-1:0] ctgt;
  logic              na;
  logic              nb;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [WORD_W-1:0] rdata;

  logic              div_start;
  logic              div_done;
  logic [WORD_W-1:0] div_q;
  logic [WORD_W-1:0] div_r;
  logic [WORD_W-1:0] mag_a;
  logic [WORD_W-1:0] mag_b;

  logic              sp_empty;
  logic              sp_full;
  logic              idx_bad;
  logic [ADDR_W-1:0] deep_addr;
  logic [ADDR_W-1:0] sp_m1;
  logic [ADDR_W-1:0] sp_m2;
  logic              out_free;
  logic              call_ok;
  logic              push_ok;

  assign sp_empty  = (sp == '0);
  assign sp_full   = (sp == SP_W'(STACK_DEPTH));
  assign idx_bad   = (CMP_W'(q_cmd.imm) >= CMP_W'(sp));
  assign deep_addr = ADDR_W'(sp - SP_W'(1) - SP_W'(q_cmd.imm));
  assign sp_m1     = ADDR_W'(sp - SP_W'(1));
  assign sp_m2     = ADDR_W'(sp - SP_W'(2));
  assign out_free  = !out_valid || !out_stall;
  assign mag_a     = rdata[WORD_W-1] ? (WORD_W'(0) - rdata) : rdata;
  assign mag_b     = top[WORD_W-1] ? (WORD_W'(0) - top) : top;
  assign call_ok   = q_valid && (st_next == ST_OK) && (q_cmd.kind == K_CALL);
  assign push_ok   = q_valid && (st_next == ST_OK) && (q_cmd.kind == K_PUSH);

  smeu_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  smeu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  // launch decision and memory control
  always_comb begin
    state_next = state;
    st_next    = ST_OK;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = sp_m1;
    wdata      = rdata;
    raddr      = sp_m2;
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = S_DONE;
          case (q_cmd.kind)
            K_PUSH: begin
              if (sp_full) st_next = ST_OVER;
              else begin
                we    = 1'b1;
                waddr = ADDR_W'(sp);
                wdata = WORD_W'(q_cmd.imm);
              end
            end
            K_PICK: begin
              if (sp_empty) st_next = ST_UNDER;
              else if (idx_bad) st_next = ST_BADIDX;
              else if (sp_full) st_next = ST_OVER;
              else begin
                raddr      = deep_addr;
                state_next = S_PICK;
              end
            end
            K_ROLL: begin
              if (sp_empty) st_next = ST_UNDER;
              else if (idx_bad) st_next = ST_BADIDX;
              else if (q_cmd.imm != 8'd0) begin
                raddr      = deep_addr;
                state_next = S_ROLL_V;
              end
            end
            K_ALU: begin
              if (sp < SP_W'(2)) st_next = ST_UNDER;
              else state_next = S_ALU_A;
            end
            K_CALL: begin
              if (sp_empty) st_next = ST_UNDER;
              else if (sp >= SP_W'(2)) state_next = S_CALL_RD;
            end
            default: st_next = ST_BADOP;
          endcase
        end
      end
      S_PICK: begin
        we         = 1'b1;
        waddr      = ADDR_W'(sp);
        state_next = S_DONE;
      end
      S_ROLL_V: begin
        raddr      = idx + 1'b1;
        state_next = S_ROLL_W;
      end
      S_ROLL_W: begin
        we    = 1'b1;
        waddr = idx;
        raddr = idx + ADDR_W'(2);
        if (idx == sp_m2) state_next = S_ROLL_L;
      end
      S_ROLL_L: begin
        we         = 1'b1;
        wdata      = hold;
        state_next = S_DONE;
      end
      S_ALU_A: begin
        if ((cmd.op == OP_DIV || cmd.op == OP_MOD) && top == '0) begin
          st_next    = ST_DIVZ;
          state_next = S_DONE;
        end else if (cmd.op == OP_DIV || cmd.op == OP_MOD) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_ALU_WR;
        end
      end
      S_DIV: begin
        if (div_done) state_next = S_ALU_WR;
      end
      S_ALU_WR: begin
        we         = 1'b1;
        waddr      = sp_m2;
        wdata      = res;
        state_next = S_DONE;
      end
      S_CALL_RD: state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cmd  <= q_cmd;
        st   <= st_next;
        cval <= call_ok;
        ctgt <= call_ok ? top : '0;
        idx  <= deep_addr;
        if (push_ok) top <= WORD_W'(q_cmd.imm);
      end
      S_PICK:   top <= rdata;
      S_ROLL_V: hold <= rdata;
      S_ROLL_W: idx <= idx + 1'b1;
      S_ROLL_L: top <= hold;
      S_ALU_A: begin
        st <= st_next;
        na <= rdata[WORD_W-1];
        nb <= top[WORD_W-1];
        case (cmd.op)
          OP_ADD:  res <= rdata + top;
          OP_SUB:  res <= rdata - top;
          default: res <= WORD_W'(rdata * top);
        endcase
      end
      S_DIV: begin
        if (cmd.op == OP_DIV) res <= (na ^ nb) ? (WORD_W'(0) - div_q) : div_q;
        else                  res <= na ? (WORD_W'(0) - div_r) : div_r;
      end
      S_ALU_WR:  top <= res;
      S_CALL_RD: top <= rdata;
      default: ;
    endcase

    if (rst) begin
      state     <= S_IDLE;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && q_valid && st_next == ST_OK) begin
        case (q_cmd.kind)
          K_PUSH:  sp <= sp + 1'b1;
          K_CALL:  sp <= sp - 1'b1;
          default: ;
        endcase
      end
      if (state == S_PICK)   sp <= sp + 1'b1;
      if (state == S_ALU_WR) sp <= sp - 1'b1;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end

    if (state == S_DONE && out_free) begin
      top_value   <= sp_empty ? '0 : to_out(top);
      depth       <= DEPTH_W'(sp);
      call_valid  <= cval;
      call_target <= to_out(ctgt);
      status      <= st;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/stack_machine_execute_unit_core.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_core
// stack-machine instruction execute unit with a decoupled decode queue
// ----------------------------------------------------------------------------
// usage:
//   input channel: op and imm, one instruction per transaction on
//   in_valid / in_stall; output channel: one result transaction per
//   instruction on out_valid / out_stall carrying top_value, depth,
//   call_valid, call_target and status
//   a two-entry queue sits between the decode front end and the executor,
//   so instructions keep entering while the executor works
//   instruction timing is set by the stack memory, with one write and one
//   registered read port, and the sequencer in the back end: push, shallow
//   call and stack errors go straight to S_DONE; pick passes S_PICK, call
//   with a refill S_CALL_RD, divide by zero S_ALU_A, add/sub/mul S_ALU_A
//   and S_ALU_WR; roll moves each word above the index down in turn;
//   div/mod also wait in S_DIV for the divider, one quotient bit per cycle
//   reset empties the stack and the queue and drops any pending result;
//   stack memory contents are not cleared, no clearing pass is needed
//   when out_stall is high the result holds, the executor waits, and the
//   queue fills until in_stall rises
// ----------------------------------------------------------------------------
`default_nettype none
module stack_machine_execute_unit_core import smeu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [3:0]         op,
  input  wire logic [7:0]         imm,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [OUT_W-1:0]   top_value,
  output logic      [DEPTH_W-1:0] depth,
  output logic                    call_valid,
  output logic      [OUT_W-1:0]   call_target,
  output logic      [2:0]         status
);

  // decoded instruction queue between front and back
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  smeu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .imm      (imm),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  // executor owns the stack memory, divider and result register
  smeu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_cmd       (q_cmd),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .top_value   (top_value),
    .depth       (depth),
    .call_valid  (call_valid),
    .call_target (call_target),
    .status      (status)
  );

endmodule
`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the stack execute unit: a local stack model
// predicts every result, a monitor compares each result transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import smeu_pkg::*;

  typedef struct packed {
    logic [31:0] top;
    logic [8:0]  dep;
    logic        cv;
    logic [31:0] ct;
    logic [2:0]  st;
  } exec_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  op;
  logic [7:0]  imm;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] top_value;
  logic [8:0]  depth;
  logic        call_valid;
  logic [31:0] call_target;
  logic [2:0]  status;

  stack_machine_execute_unit_core dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .imm(imm), .out_valid(out_valid), .out_stall(out_stall),
    .top_value(top_value), .depth(depth), .call_valid(call_valid),
    .call_target(call_target), .status(status)
  );

  // local stack model
  logic [31:0]  model_stack [0:STACK_DEPTH-1];
  int           model_sp;
  exec_result_t pending_results [$];
  int           fail_count;
  int           result_count;
  int           op_hits [0:15];
  longint       cycle_count;
  bit           idle_enable;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic exec_result_t execute_instruction(input logic [3:0] o,
                                                       input logic [7:0] i);
    exec_result_t r;
    logic signed [31:0] a, b, q;
    int pos;
    logic [31:0] v;
    r = '0;
    r.st = ST_OK;
    case (o)
      OP_PUSH8: begin
        if (model_sp >= STACK_DEPTH) r.st = ST_OVER;
        else begin
          model_stack[model_sp] = {24'd0, i};
          model_sp++;
        end
      end
      OP_PICK: begin
        if (model_sp == 0) r.st = ST_UNDER;
        else if (i >= model_sp) r.st = ST_BADIDX;
        else if (model_sp >= STACK_DEPTH) r.st = ST_OVER;
        else begin
          model_stack[model_sp] = model_stack[model_sp - 1 - i];
          model_sp++;
        end
      end
      OP_ROLL: begin
        if (model_sp == 0) r.st = ST_UNDER;
        else if (i >= model_sp) r.st = ST_BADIDX;
        else begin
          pos = model_sp - 1 - i;
          v = model_stack[pos];
          for (int k = pos; k + 1 < model_sp; k++) model_stack[k] = model_stack[k + 1];
          model_stack[model_sp - 1] = v;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
        if (model_sp < 2) r.st = ST_UNDER;
        else begin
          a = model_stack[model_sp - 2];
          b = model_stack[model_sp - 1];
          q = '0;
          if ((o == OP_DIV || o == OP_MOD) && b == 0) r.st = ST_DIVZ;
          else begin
            case (o)
              OP_ADD: q = a + b;
              OP_SUB: q = a - b;
              OP_MUL: q = a * b;
              // min / -1 wraps to min, remainder zero
              OP_DIV: q = (a == 32'sh80000000 && b == -1) ? a : a / b;
              default: q = (b == -1) ? 32'sd0 : a % b;
            endcase
            model_stack[model_sp - 2] = q;
            model_sp--;
          end
        end
      end
      OP_CALL: begin
        if (model_sp == 0) r.st = ST_UNDER;
        else begin
          r.cv = 1'b1;
          r.ct = model_stack[model_sp - 1];
          model_sp--;
        end
      end
      default: r.st = ST_BADOP;
    endcase
    r.dep = model_sp[8:0];
    r.top = (model_sp > 0) ? model_stack[model_sp - 1] : 32'd0;
    return r;
  endfunction

  // send one instruction, predict at acceptance
  task automatic send_instruction(input logic [3:0] o, input logic [7:0] i);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    imm <= i;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute_instruction(o, i));
    op_hits[o]++;
    @(negedge clk);
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      exec_result_t got, exp_r;
      got = '{top_value, depth, call_valid, call_target, status};
      result_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.top !== exp_r.top) begin
          $display("%0t: top_value expected %h actual %h", $time, exp_r.top, got.top);
          fail_count++;
        end
        if (got.dep !== exp_r.dep) begin
          $display("%0t: depth expected %0d actual %0d", $time, exp_r.dep, got.dep);
          fail_count++;
        end
        if (got.cv !== exp_r.cv) begin
          $display("%0t: call_valid expected %b actual %b", $time, exp_r.cv, got.cv);
          fail_count++;
        end
        if (got.ct !== exp_r.ct) begin
          $display("%0t: call_target expected %h actual %h", $time, exp_r.ct, got.ct);
          fail_count++;
        end
        if (got.st !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, got.st);
          fail_count++;
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2000000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [31:0] w);
    // build an arbitrary word from bytes: push hi, then per lower byte push 16, push 16, mul, mul, push the byte, add
    send_instruction(OP_PUSH8, w[31:24]);
    for (int k = 2; k >= 0; k--) begin
      send_instruction(OP_PUSH8, 8'd16);
      send_instruction(OP_PUSH8, 8'd16);
      send_instruction(OP_MUL, 8'd0);
      send_instruction(OP_MUL, 8'd0);
      send_instruction(OP_PUSH8, w[k*8 +: 8]);
      send_instruction(OP_ADD, 8'd0);
    end
  endtask

  task automatic drain_stack();
    while (model_sp > 0) send_instruction(OP_CALL, 8'd0);
  endtask

  task automatic test_directed();
    // errors on empty stack and bad opcodes, then a bad pick index, divide by zero and valid ops
    send_instruction(OP_PICK, 8'd0);
    send_instruction(OP_ROLL, 8'd0);
    send_instruction(OP_ADD, 8'd0);
    send_instruction(OP_CALL, 8'd0);
    send_instruction(4'd9, 8'd0);
    send_instruction(4'd15, 8'hff);
    send_instruction(OP_PUSH8, 8'hff);
    send_instruction(OP_PUSH8, 8'd0);
    send_instruction(OP_PICK, 8'd2);
    send_instruction(OP_DIV, 8'd0);
    send_instruction(OP_MOD, 8'd0);
    send_instruction(OP_PICK, 8'd1);
    send_instruction(OP_ROLL, 8'd1);
    send_instruction(OP_SUB, 8'd0);
    send_instruction(OP_PUSH8, 8'd7);
    send_instruction(OP_MUL, 8'd0);
    send_instruction(OP_CALL, 8'd0);
  endtask

  task automatic test_division_corners();
    // most negative over minus one, signs of quotient and remainder
    push_word(32'h80000000);
    push_word(32'hffffffff);
    send_instruction(OP_PICK, 8'd1);
    send_instruction(OP_PICK, 8'd1);
    send_instruction(OP_DIV, 8'd0);
    send_instruction(OP_CALL, 8'd0);
    send_instruction(OP_MOD, 8'd0);
    push_word(32'hfffffff9);
    send_instruction(OP_PUSH8, 8'd2);
    send_instruction(OP_PICK, 8'd1);
    send_instruction(OP_PICK, 8'd1);
    send_instruction(OP_MOD, 8'd0);
    send_instruction(OP_ROLL, 8'd2);
    send_instruction(OP_ROLL, 8'd2);
    send_instruction(OP_DIV, 8'd0);
    push_word(32'h7fffffff);
    send_instruction(OP_PUSH8, 8'd1);
    send_instruction(OP_ADD, 8'd0);
    drain_stack();
  endtask

  task automatic test_full_stack();
    // fill, then overflow on push and pick, deep rolls, a mod and a deep pick out of range
    while (model_sp < STACK_DEPTH) send_instruction(OP_PUSH8, 8'($urandom));
    send_instruction(OP_PUSH8, 8'd1);
    send_instruction(OP_PICK, 8'd0);
    send_instruction(OP_ROLL, 8'd255);
    send_instruction(OP_PICK, 8'd255);
    send_instruction(OP_ROLL, 8'd128);
    send_instruction(OP_MOD, 8'd0);
    send_instruction(OP_PICK, 8'd255);
    drain_stack();
  endtask

  task automatic test_random(input int n);
    logic [3:0] o;
    logic [7:0] i;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 30) o = OP_PUSH8;
      else if (r < 40) o = OP_PICK;
      else if (r < 50) o = OP_ROLL;
      else if (r < 90) o = 4'($urandom_range(OP_ADD, OP_CALL));
      else o = 4'($urandom);
      // mostly valid depth indexes, sometimes anything
      if ((o == OP_PICK || o == OP_ROLL) && model_sp > 0 && $urandom_range(0, 3) != 0)
        i = 8'($urandom_range(0, (model_sp > 256 ? 256 : model_sp) - 1));
      else i = 8'($urandom);
      send_instruction(o, i);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    op = '0;
    imm = '0;
    fail_count = 0;
    result_count = 0;
    idle_enable = 1'b1;
    model_sp = 0;
    foreach (op_hits[k]) op_hits[k] = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_division_corners();
    test_full_stack();
    test_random(500);
    idle_enable = 1'b0;
    test_random(220);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("ran %0d results; push %0d pick %0d roll %0d call %0d div %0d mod %0d",
             result_count, op_hits[OP_PUSH8], op_hits[OP_PICK], op_hits[OP_ROLL],
             op_hits[OP_CALL], op_hits[OP_DIV], op_hits[OP_MOD]);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
